[hdl/gqr_pkg.sv]
// ----------------------------------------------------------------------------
// gqr_pkg
// Word types and fixed codes shared by the Givens QR block and its checker.
// ----------------------------------------------------------------------------
package gqr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COEF_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_REDUCED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic SEL_Q = 1'b0;
    localparam logic SEL_R = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [1:0]         element_row;
        logic [1:0]         element_col;
        logic signed [31:0] element_value;
    } t_in_word;

    typedef struct packed {
        logic               matrix_sel;
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [31:0] out_value;
        logic               saturated;
        logic               last;
    } t_out_word;

endpackage

[hdl/givens_qr_decomposition_top.sv]
// ----------------------------------------------------------------------------
// givens_qr_decomposition_top
// Givens-rotation QR decomposition of a small fixed-point matrix held in RAM.
// ----------------------------------------------------------------------------
// Load words (cmd 0) write one element of A, one per cycle. A start word
// (cmd 1) runs the decomposition in place and then emits Q and R row-major,
// one word per element. R and Q share one RAM with a registered read; each
// step reads, computes and writes back in strict order, so a read never
// overlaps a pending write. A run first sets Q to the identity, then per
// rotation prescales the pair by shifting, takes the 32-step square root
// and the 17-step divider, writes R and rotates each element pair in R and
// Q; a rotation whose lower element is zero is skipped. Before emitting, a
// scan over every element settles the saturation flag, then each result
// word is held until accepted. No input is taken until the last result word
// has been accepted.
// ----------------------------------------------------------------------------
module givens_qr_decomposition_top
    import gqr_pkg::*;
#(
    parameter int MAX_DIM     = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_word              i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_word             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DD   = MAX_DIM * MAX_DIM;
    localparam int XW   = (VALUE_WIDTH > 18) ? VALUE_WIDTH : 18;
    localparam int BW   = (XW > 32) ? XW : 32;
    localparam int RW   = BW + 2;
    localparam int CMPW = BW + 3;
    localparam int PW   = XW + COEF_W;
    localparam int AW   = $clog2(2 * DD);
    localparam int CW   = $clog2(MAX_DIM + 1);
    localparam int SHW  = $clog2(BW);

    localparam logic signed [CMPW-1:0] VMAX = $signed((CMPW'(1) << (VALUE_WIDTH - 1))
                                                      - CMPW'(1));
    localparam logic signed [CMPW-1:0] VMIN = -VMAX - CMPW'(1);
    localparam logic signed [CMPW-1:0] IMAX = $signed(CMPW'(32'h7fff_ffff));
    localparam logic signed [CMPW-1:0] IMIN = -IMAX - CMPW'(1);
    localparam logic [XW-1:0]          ONE  = XW'(1) << FRAC_BITS;
    localparam logic [COEF_W-1:0]      CONE = COEF_W'(1) << FRAC_BITS;
    localparam logic [CW-1:0]          DLAST = CW'(MAX_DIM - 1);

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_QINIT   = 22'h000002,
        S_ROT_CHK = 22'h000004,
        S_RD_AB   = 22'h000008,
        S_GET_AB  = 22'h000010,
        S_SHIFT   = 22'h000020,
        S_SUMSQ   = 22'h000040,
        S_SQRT    = 22'h000080,
        S_ROOT    = 22'h000100,
        S_DIV     = 22'h000200,
        S_WR_R    = 22'h000400,
        S_WR_Z    = 22'h000800,
        S_EL_RD   = 22'h001000,
        S_EL_MUL  = 22'h002000,
        S_EL_SUM  = 22'h004000,
        S_EL_WX   = 22'h008000,
        S_EL_WY   = 22'h010000,
        S_CHK_RD  = 22'h020000,
        S_CHK_GET = 22'h040000,
        S_EM_RD   = 22'h080000,
        S_EM_GET  = 22'h100000,
        S_EM_WAIT = 22'h200000
    } t_state;

    function automatic logic [AW-1:0] f_addr(input logic sel, input logic [CW-1:0] row,
                                             input logic [CW-1:0] col);
        f_addr = (sel ? AW'(DD) : AW'(0)) + AW'(row) * AW'(MAX_DIM) + AW'(col);
    endfunction

    // {flag, value}
    function automatic logic [XW:0] f_clamp(input logic signed [CMPW-1:0] v);
        if (v > VMAX) begin
            f_clamp = {1'b1, XW'(VMAX)};
        end else if (v < VMIN) begin
            f_clamp = {1'b1, XW'(VMIN)};
        end else begin
            f_clamp = {1'b0, XW'(v)};
        end
    endfunction

    function automatic logic [32:0] f_clamp32(input logic [XW-1:0] x);
        logic signed [CMPW-1:0] v;
        v = CMPW'($signed(x));
        if (v > IMAX) begin
            f_clamp32 = {1'b1, 32'h7fff_ffff};
        end else if (v < IMIN) begin
            f_clamp32 = {1'b1, 32'h8000_0000};
        end else begin
            f_clamp32 = {1'b0, v[31:0]};
        end
    endfunction

    function automatic logic [XW-1:0] f_mag(input logic [XW-1:0] x);
        f_mag = x[XW-1] ? (XW'(0) - x) : x;
    endfunction

    function automatic logic [CW-1:0] f_dim(input logic [2:0] v);
        if (v == 3'd0) begin
            f_dim = CW'(1);
        end else if (v > 3'(MAX_DIM)) begin
            f_dim = CW'(MAX_DIM);
        end else begin
            f_dim = CW'(v);
        end
    endfunction

    t_state                 r_state, n_state;
    logic                   r_cfg_red, n_cfg_red;
    logic [2:0]             r_cfg_rows, n_cfg_rows;
    logic [2:0]             r_cfg_cols, n_cfg_cols;
    logic                   r_ovf, n_ovf;
    logic [CW-1:0]          r_j, n_j;
    logic [CW-1:0]          r_i, n_i;
    logic [CW-1:0]          r_k, n_k;
    logic                   r_onq, n_onq;
    logic                   r_sel, n_sel;
    logic [CW-1:0]          r_row, n_row;
    logic [CW-1:0]          r_col, n_col;
    logic [XW-1:0]          r_ma, n_ma;
    logic [XW-1:0]          r_mb, n_mb;
    logic                   r_na, n_na;
    logic                   r_nb, n_nb;
    logic [BW-1:0]          r_sa, n_sa;
    logic [BW-1:0]          r_sb, n_sb;
    logic [SHW-1:0]         r_sh, n_sh;
    logic [61:0]            r_pa, n_pa;
    logic [61:0]            r_pb, n_pb;
    logic [63:0]            r_x, n_x;
    logic [63:0]            r_res, n_res;
    logic [63:0]            r_bit, n_bit;
    logic [RW-1:0]          r_rv, n_rv;
    logic [RW:0]            r_rema, n_rema;
    logic [RW:0]            r_remb, n_remb;
    logic [COEF_W-1:0]      r_qa, n_qa;
    logic [COEF_W-1:0]      r_qb, n_qb;
    logic [4:0]             r_dcnt, n_dcnt;
    logic [COEF_W-1:0]      r_cm, n_cm;
    logic [COEF_W-1:0]      r_smg, n_smg;
    logic                   r_cneg, n_cneg;
    logic                   r_sneg, n_sneg;
    logic [PW-1:0]          r_p0, n_p0, r_p1, n_p1, r_p2, n_p2, r_p3, n_p3;
    logic                   r_s0, n_s0, r_s1, n_s1, r_s2, n_s2, r_s3, n_s3;
    logic [XW-1:0]          r_nx, n_nx;
    logic [XW-1:0]          r_ny, n_ny;
    t_out_word              r_out, n_out;
    logic                   r_oval, n_oval;

    logic [XW-1:0]          r_mem [2*DD];
    logic [XW-1:0]          r_rd_a, r_rd_b;
    logic [AW-1:0]          raddr_a, raddr_b, waddr;
    logic [XW-1:0]          wdata;
    logic                   we;

    logic [CW-1:0]          dim_m, dim_n, lim, qc, rr, ncols, nrows;
    logic                   red_eff, seq_row_end, seq_done, seq_last;
    logic [AW-1:0]          el_xa, el_ya;

    // derived dimensions
    always_comb begin
        dim_m   = f_dim(r_cfg_rows);
        dim_n   = f_dim(r_cfg_cols);
        lim     = (dim_m < dim_n) ? dim_m : dim_n;
        red_eff = r_cfg_red && (dim_n <= dim_m);
        qc      = red_eff ? dim_n : dim_m;
        rr      = red_eff ? dim_n : dim_m;
        ncols   = r_sel ? dim_n : qc;
        nrows   = r_sel ? rr : dim_m;
        seq_row_end = (r_col + CW'(1)) == ncols;
        seq_done    = seq_row_end && ((r_row + CW'(1)) == nrows);
        seq_last    = r_sel && seq_done;
        el_xa = r_onq ? f_addr(SEL_Q, r_k, r_i - CW'(1)) : f_addr(SEL_R, r_i - CW'(1), r_k);
        el_ya = r_onq ? f_addr(SEL_Q, r_k, r_i) : f_addr(SEL_R, r_i, r_k);
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_oval;
    assign o_data  = r_out;

    always_comb begin
        logic [XW:0]            cl_a, cl_b;
        logic [32:0]            c32;
        logic [XW-1:0]          xm, ym;
        logic signed [CMPW-1:0] t0, t1, t2, t3;
        logic [63:0]            rb;
        logic [RW:0]            ca, cb;
        logic                   ga, gb;

        n_state = r_state;   n_cfg_red = r_cfg_red; n_cfg_rows = r_cfg_rows;
        n_cfg_cols = r_cfg_cols; n_ovf = r_ovf; n_j = r_j; n_i = r_i; n_k = r_k;
        n_onq = r_onq; n_sel = r_sel; n_row = r_row; n_col = r_col;
        n_ma = r_ma; n_mb = r_mb; n_na = r_na; n_nb = r_nb; n_sa = r_sa; n_sb = r_sb;
        n_sh = r_sh; n_pa = r_pa; n_pb = r_pb; n_x = r_x; n_res = r_res; n_bit = r_bit;
        n_rv = r_rv; n_rema = r_rema; n_remb = r_remb; n_qa = r_qa; n_qb = r_qb;
        n_dcnt = r_dcnt; n_cm = r_cm; n_smg = r_smg; n_cneg = r_cneg; n_sneg = r_sneg;
        n_p0 = r_p0; n_p1 = r_p1; n_p2 = r_p2; n_p3 = r_p3;
        n_s0 = r_s0; n_s1 = r_s1; n_s2 = r_s2; n_s3 = r_s3;
        n_nx = r_nx; n_ny = r_ny; n_out = r_out; n_oval = r_oval;
        raddr_a = f_addr(r_sel, r_row, r_col);
        raddr_b = el_ya;
        waddr   = el_xa;
        wdata   = r_nx;
        we      = 1'b0;
        cl_a = '0; cl_b = '0; c32 = '0; xm = '0; ym = '0;
        t0 = '0; t1 = '0; t2 = '0; t3 = '0; rb = '0; ca = '0; cb = '0; ga = 1'b0; gb = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REDUCED: n_cfg_red  = i_cfg_data[0];
                CFG_ROWS:    n_cfg_rows = i_cfg_data;
                CFG_COLS:    n_cfg_cols = i_cfg_data;
                default:     ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.cmd == CMD_START) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_state = S_QINIT;
                    end else if (CW'(i_data.element_row) < CW'(MAX_DIM)
                                 && CW'(i_data.element_col) < CW'(MAX_DIM)) begin
                        cl_a  = f_clamp(CMPW'(i_data.element_value));
                        we    = 1'b1;
                        waddr = f_addr(SEL_R, CW'(i_data.element_row),
                                       CW'(i_data.element_col));
                        wdata = cl_a[XW-1:0];
                        if (cl_a[XW]) n_ovf = 1'b1;
                    end
                end
            end
            S_QINIT: begin
                we    = 1'b1;
                waddr = f_addr(SEL_Q, r_row, r_col);
                wdata = (r_row == r_col) ? ONE : '0;
                if (r_col == DLAST) begin
                    n_col = '0;
                    n_row = r_row + CW'(1);
                    if (r_row == DLAST) begin
                        n_j     = '0;
                        n_i     = dim_m - CW'(1);
                        n_state = S_ROT_CHK;
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            S_ROT_CHK: begin
                if (r_j >= lim) begin
                    n_sel   = SEL_Q;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_CHK_RD;
                end else if (r_i > r_j) begin
                    n_state = S_RD_AB;
                end else begin
                    n_j = r_j + CW'(1);
                    n_i = dim_m - CW'(1);
                end
            end
            S_RD_AB: begin
                raddr_a = f_addr(SEL_R, r_i - CW'(1), r_j);
                raddr_b = f_addr(SEL_R, r_i, r_j);
                n_state = S_GET_AB;
            end
            S_GET_AB: begin
                if (r_rd_b == '0) begin
                    n_i     = r_i - CW'(1);
                    n_state = S_ROT_CHK;
                end else begin
                    n_ma    = f_mag(r_rd_a);
                    n_mb    = f_mag(r_rd_b);
                    n_na    = r_rd_a[XW-1];
                    n_nb    = r_rd_b[XW-1];
                    n_sa    = BW'(f_mag(r_rd_a));
                    n_sb    = BW'(f_mag(r_rd_b));
                    n_sh    = '0;
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if ((|r_sa[BW-1:31]) || (|r_sb[BW-1:31])) begin
                    n_sa = r_sa >> 1;
                    n_sb = r_sb >> 1;
                    n_sh = r_sh + SHW'(1);
                end else begin
                    n_pa    = r_sa[30:0] * r_sa[30:0];
                    n_pb    = r_sb[30:0] * r_sb[30:0];
                    n_state = S_SUMSQ;
                end
            end
            S_SUMSQ: begin
                n_x     = 64'(r_pa) + 64'(r_pb);
                n_res   = '0;
                n_bit   = 64'(1) << 62;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                rb = r_res + r_bit;
                if (r_x >= rb) begin
                    n_x   = r_x - rb;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) n_state = S_ROOT;
            end
            S_ROOT: begin
                n_rv    = RW'(r_res[31:0]) << r_sh;
                n_rema  = (RW+1)'(r_ma);
                n_remb  = (RW+1)'(r_mb);
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                ca = (r_dcnt == '0) ? r_rema : {r_rema[RW-1:0], 1'b0};
                cb = (r_dcnt == '0) ? r_remb : {r_remb[RW-1:0], 1'b0};
                ga = ca >= (RW+1)'(r_rv);
                gb = cb >= (RW+1)'(r_rv);
                n_rema = ga ? (ca - (RW+1)'(r_rv)) : ca;
                n_remb = gb ? (cb - (RW+1)'(r_rv)) : cb;
                n_qa   = {r_qa[COEF_W-2:0], ga};
                n_qb   = {r_qb[COEF_W-2:0], gb};
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'(COEF_W - 1)) n_state = S_WR_R;
            end
            S_WR_R: begin
                cl_a    = f_clamp($signed(CMPW'(r_rv)));
                we      = 1'b1;
                waddr   = f_addr(SEL_R, r_i - CW'(1), r_j);
                wdata   = cl_a[XW-1:0];
                if (cl_a[XW]) n_ovf = 1'b1;
                n_cm    = (r_qa > CONE) ? CONE : r_qa;
                n_smg   = (r_qb > CONE) ? CONE : r_qb;
                n_cneg  = r_na;
                n_sneg  = r_nb;
                n_state = S_WR_Z;
            end
            S_WR_Z: begin
                we    = 1'b1;
                waddr = f_addr(SEL_R, r_i, r_j);
                wdata = '0;
                if ((r_j + CW'(1)) < dim_n) begin
                    n_onq = 1'b0;
                    n_k   = r_j + CW'(1);
                end else begin
                    n_onq = 1'b1;
                    n_k   = '0;
                end
                n_state = S_EL_RD;
            end
            S_EL_RD: begin
                raddr_a = el_xa;
                raddr_b = el_ya;
                n_state = S_EL_MUL;
            end
            S_EL_MUL: begin
                xm   = f_mag(r_rd_a);
                ym   = f_mag(r_rd_b);
                n_p0 = PW'(xm) * PW'(r_cm);
                n_p1 = PW'(ym) * PW'(r_smg);
                n_p2 = PW'(ym) * PW'(r_cm);
                n_p3 = PW'(xm) * PW'(r_smg);
                n_s0 = r_rd_a[XW-1] ^ r_cneg;
                n_s1 = r_rd_b[XW-1] ^ r_sneg;
                n_s2 = r_rd_b[XW-1] ^ r_cneg;
                n_s3 = r_rd_a[XW-1] ^ r_sneg;
                n_state = S_EL_SUM;
            end
            S_EL_SUM: begin
                t0 = $signed(CMPW'(r_p0[PW-1:FRAC_BITS]));
                t1 = $signed(CMPW'(r_p1[PW-1:FRAC_BITS]));
                t2 = $signed(CMPW'(r_p2[PW-1:FRAC_BITS]));
                t3 = $signed(CMPW'(r_p3[PW-1:FRAC_BITS]));
                if (r_s0) t0 = -t0;
                if (r_s1) t1 = -t1;
                if (r_s2) t2 = -t2;
                if (r_s3) t3 = -t3;
                cl_a = f_clamp(t0 + t1);
                cl_b = f_clamp(t2 - t3);
                n_nx = cl_a[XW-1:0];
                n_ny = cl_b[XW-1:0];
                if (cl_a[XW] || cl_b[XW]) n_ovf = 1'b1;
                n_state = S_EL_WX;
            end
            S_EL_WX: begin
                we      = 1'b1;
                waddr   = el_xa;
                wdata   = r_nx;
                n_state = S_EL_WY;
            end
            S_EL_WY: begin
                we    = 1'b1;
                waddr = el_ya;
                wdata = r_ny;
                if (!r_onq) begin
                    if ((r_k + CW'(1)) < dim_n) begin
                        n_k = r_k + CW'(1);
                    end else begin
                        n_onq = 1'b1;
                        n_k   = '0;
                    end
                    n_state = S_EL_RD;
                end else if ((r_k + CW'(1)) < dim_m) begin
                    n_k     = r_k + CW'(1);
                    n_state = S_EL_RD;
                end else begin
                    n_i     = r_i - CW'(1);
                    n_state = S_ROT_CHK;
                end
            end
            S_CHK_RD: begin
                raddr_a = f_addr(r_sel, r_row, r_col);
                n_state = S_CHK_GET;
            end
            S_CHK_GET: begin
                c32 = f_clamp32(r_rd_a);
                if (c32[32]) n_ovf = 1'b1;
                if (seq_last) begin
                    n_sel   = SEL_Q;
                    n_row   = '0;
                    n_col   = '0;
                    n_state = S_EM_RD;
                end else begin
                    if (seq_done) begin
                        n_sel = SEL_R;
                        n_row = '0;
                        n_col = '0;
                    end else if (seq_row_end) begin
                        n_row = r_row + CW'(1);
                        n_col = '0;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                    n_state = S_CHK_RD;
                end
            end
            S_EM_RD: begin
                raddr_a = f_addr(r_sel, r_row, r_col);
                n_state = S_EM_GET;
            end
            S_EM_GET: begin
                c32              = f_clamp32(r_rd_a);
                n_out.matrix_sel = r_sel;
                n_out.out_row    = r_row[1:0];
                n_out.out_col    = r_col[1:0];
                n_out.out_value  = c32[31:0];
                n_out.saturated  = r_ovf;
                n_out.last       = seq_last;
                n_oval           = 1'b1;
                n_state          = S_EM_WAIT;
            end
            S_EM_WAIT: begin
                if (i_ready) begin
                    n_oval = 1'b0;
                    if (seq_last) begin
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        if (seq_done) begin
                            n_sel = SEL_R;
                            n_row = '0;
                            n_col = '0;
                        end else if (seq_row_end) begin
                            n_row = r_row + CW'(1);
                            n_col = '0;
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                        n_state = S_EM_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Q region at 0, R region at DD
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[raddr_a];
        r_rd_b <= r_mem[raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_red  <= 1'b0;
            r_cfg_rows <= 3'd4;
            r_cfg_cols <= 3'd4;
            r_ovf      <= 1'b0;
            r_oval     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cfg_red  <= n_cfg_red;
            r_cfg_rows <= n_cfg_rows;
            r_cfg_cols <= n_cfg_cols;
            r_ovf      <= n_ovf;
            r_oval     <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j <= n_j; r_i <= n_i; r_k <= n_k; r_onq <= n_onq;
        r_sel <= n_sel; r_row <= n_row; r_col <= n_col;
        r_ma <= n_ma; r_mb <= n_mb; r_na <= n_na; r_nb <= n_nb;
        r_sa <= n_sa; r_sb <= n_sb; r_sh <= n_sh; r_pa <= n_pa; r_pb <= n_pb;
        r_x <= n_x; r_res <= n_res; r_bit <= n_bit; r_rv <= n_rv;
        r_rema <= n_rema; r_remb <= n_remb; r_qa <= n_qa; r_qb <= n_qb;
        r_dcnt <= n_dcnt; r_cm <= n_cm; r_smg <= n_smg;
        r_cneg <= n_cneg; r_sneg <= n_sneg;
        r_p0 <= n_p0; r_p1 <= n_p1; r_p2 <= n_p2; r_p3 <= n_p3;
        r_s0 <= n_s0; r_s1 <= n_s1; r_s2 <= n_s2; r_s3 <= n_s3;
        r_nx <= n_nx; r_ny <= n_ny; r_out <= n_out;
    end

endmodule

[hdl/gqr_checker.sv]
// ----------------------------------------------------------------------------
// gqr_checker
// Port-level checks on the Givens QR block's result channel.
// ----------------------------------------------------------------------------
module gqr_checker
    import gqr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a result word is pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result word changed");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_data.last |=> !o_valid && o_ready)
        else $error("run did not end after last word");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last |=> !o_ready)
        else $error("input taken in the middle of a run");

endmodule

bind givens_qr_decomposition_top gqr_checker u_gqr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
